@@ design/khtu_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// khtu_pkg: shared types and constants of the keyed history table
// Field widths, table geometry, operation codes and controller states.
// ---------------------------------------------------------------------------
package khtu_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Transaction field widths.
  localparam int OP_W   = 3;
  localparam int KEY_W  = 16;
  localparam int VAL_W  = 16;
  localparam int EIDX_W = 10;
  localparam int ECNT_W = 11;

  // One stored entry: key in the upper half, value in the lower half.
  localparam int ENTRY_W = KEY_W + VAL_W;

  typedef enum logic [OP_W-1:0] {
    OP_UPSERT    = 3'd0,
    OP_READ_IDX  = 3'd1,
    OP_READ_LAST = 3'd2,
    OP_CLEAR     = 3'd3,
    OP_SCAN      = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } state_t;

endpackage

@@ design/khtu_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// khtu_if: channel interfaces of the keyed history table
// Request and response channels with a valid/ready handshake.
// ---------------------------------------------------------------------------
interface khtu_in_if;
  logic                       valid;
  logic                       ready;
  logic [khtu_pkg::OP_W-1:0]   operation;
  logic [khtu_pkg::KEY_W-1:0]  day_key;
  logic [khtu_pkg::VAL_W-1:0]  new_value;
  logic [khtu_pkg::EIDX_W-1:0] entry_index;

  modport source (output valid, operation, day_key, new_value, entry_index, input ready);
  modport sink   (input valid, operation, day_key, new_value, entry_index, output ready);
endinterface

interface khtu_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [khtu_pkg::KEY_W-1:0]  out_key;
  logic [khtu_pkg::VAL_W-1:0]  out_value;
  logic [khtu_pkg::VAL_W-1:0]  min_value;
  logic [khtu_pkg::VAL_W-1:0]  max_value;
  logic [khtu_pkg::ECNT_W-1:0] entry_count;

  modport source (output valid, found, out_key, out_value, min_value, max_value,
                  entry_count, input ready);
  modport sink   (input valid, found, out_key, out_value, min_value, max_value,
                  entry_count, output ready);
endinterface

@@ design/keyed_history_table_upsert.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// keyed_history_table_upsert: bounded oldest-first table of (key, value)
//
// Requests arrive on in_chan, one transaction per operation: upsert, read by
// index, read latest, clear, or min/max scan. Each request yields exactly one
// response transaction on out_chan, which always reports the entry count.
// The entries live in one 1024 x 32 synchronous memory kept as a ring
// (oldest slot plus count). Upsert and scan walk the stored entries through
// the single read port, one entry per cycle; an upsert stops early on a hit.
// Reads that find an entry pass through the read state before the result is
// ready; clear, reads that miss, unknown codes and operations on an empty
// table go straight to the done state.
// One request is processed at a time: in_chan.ready is high while the
// controller is idle, and the next request may be taken while the previous
// response still waits in the output register. If out_chan is stalled, a
// finished result waits in the controller until the output register frees.
// Reset (synchronous, active low) empties the table at once; the memory
// contents are not cleared, since only slots below the count are ever read.
// ---------------------------------------------------------------------------
module keyed_history_table_upsert (
  input  logic              clk,
  input  logic              rst_n,
  khtu_in_if.sink           in_chan,
  khtu_out_if.source        out_chan
);

  localparam int SUM_W = khtu_pkg::IDX_W + 1;

  // Ring position to memory slot: (head + pos) mod depth.
  function automatic logic [khtu_pkg::IDX_W-1:0] slot_of(
    input logic [khtu_pkg::IDX_W-1:0] head,
    input logic [khtu_pkg::IDX_W-1:0] pos
  );
    logic [SUM_W-1:0] sum;
    sum = {1'b0, head} + {1'b0, pos};
    if (sum >= SUM_W'(khtu_pkg::TABLE_DEPTH)) begin
      sum = sum - SUM_W'(khtu_pkg::TABLE_DEPTH);
    end
    return sum[khtu_pkg::IDX_W-1:0];
  endfunction

  // Entry memory.
  logic [khtu_pkg::ENTRY_W-1:0] mem [khtu_pkg::TABLE_DEPTH];
  logic [khtu_pkg::ENTRY_W-1:0] rd_data_r;
  logic                         rd_en;
  logic [khtu_pkg::IDX_W-1:0]   rd_slot;
  logic                         wr_en;
  logic [khtu_pkg::IDX_W-1:0]   wr_slot;
  logic [khtu_pkg::ENTRY_W-1:0] wr_data;

  // Control state.
  khtu_pkg::state_t state_r, state_nxt;
  logic [khtu_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [khtu_pkg::IDX_W-1:0] oldest_r, oldest_nxt;
  logic [khtu_pkg::CNT_W-1:0] rd_pos_r, rd_pos_nxt;
  logic                       cmp_vld_r, cmp_vld_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Per-request payload.
  khtu_pkg::op_t              op_r, op_nxt;
  logic [khtu_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [khtu_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [khtu_pkg::IDX_W-1:0] cmp_slot_r, cmp_slot_nxt;
  logic [khtu_pkg::CNT_W-1:0] cmp_pos_r, cmp_pos_nxt;
  logic [khtu_pkg::VAL_W-1:0] min_r, min_nxt;
  logic [khtu_pkg::VAL_W-1:0] max_r, max_nxt;

  // Pending result.
  logic                       res_found_r, res_found_nxt;
  logic [khtu_pkg::KEY_W-1:0] res_key_r, res_key_nxt;
  logic [khtu_pkg::VAL_W-1:0] res_val_r, res_val_nxt;
  logic [khtu_pkg::VAL_W-1:0] res_min_r, res_min_nxt;
  logic [khtu_pkg::VAL_W-1:0] res_max_r, res_max_nxt;

  // Output register.
  logic                        out_found_r, out_found_nxt;
  logic [khtu_pkg::KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [khtu_pkg::VAL_W-1:0]  out_val_r, out_val_nxt;
  logic [khtu_pkg::VAL_W-1:0]  out_min_r, out_min_nxt;
  logic [khtu_pkg::VAL_W-1:0]  out_max_r, out_max_nxt;
  logic [khtu_pkg::ECNT_W-1:0] out_cnt_r, out_cnt_nxt;

  // Helper signals.
  logic                       in_accept;
  logic                       table_full;
  logic [khtu_pkg::IDX_W-1:0] app_slot;
  logic [khtu_pkg::IDX_W-1:0] oldest_inc;
  logic [khtu_pkg::IDX_W-1:0] rd_pos_sel;
  logic [khtu_pkg::KEY_W-1:0] upd_key;
  logic [khtu_pkg::VAL_W-1:0] upd_val;
  logic [khtu_pkg::KEY_W-1:0] rd_key;
  logic [khtu_pkg::VAL_W-1:0] rd_val;
  logic [khtu_pkg::VAL_W-1:0] mn_new;
  logic [khtu_pkg::VAL_W-1:0] mx_new;
  logic                       cmp_last;

  assign in_chan.ready = (state_r == khtu_pkg::ST_IDLE);
  assign in_accept     = in_chan.valid && (state_r == khtu_pkg::ST_IDLE);

  // Append target: the slot after the newest entry, or the oldest when full.
  assign table_full = (count_r == khtu_pkg::CNT_W'(khtu_pkg::TABLE_DEPTH));
  assign oldest_inc = (oldest_r == khtu_pkg::IDX_W'(khtu_pkg::TABLE_DEPTH - 1))
                    ? '0 : oldest_r + 1'b1;
  assign app_slot   = table_full ? oldest_r
                                 : slot_of(oldest_r, khtu_pkg::IDX_W'(count_r));
  assign upd_key    = (state_r == khtu_pkg::ST_IDLE) ? in_chan.day_key : key_r;
  assign upd_val    = (state_r == khtu_pkg::ST_IDLE) ? in_chan.new_value : val_r;

  // Read address: request position while idle, walk position while scanning.
  always_comb begin
    rd_pos_sel = khtu_pkg::IDX_W'(rd_pos_r);
    if (state_r == khtu_pkg::ST_IDLE) begin
      if (khtu_pkg::op_t'(in_chan.operation) == khtu_pkg::OP_READ_IDX) begin
        rd_pos_sel = khtu_pkg::IDX_W'(in_chan.entry_index);
      end else begin
        rd_pos_sel = khtu_pkg::IDX_W'(count_r - 1'b1);
      end
    end
  end
  assign rd_slot = slot_of(oldest_r, rd_pos_sel);

  // Fields of the entry returned by the memory.
  assign rd_key   = rd_data_r[khtu_pkg::ENTRY_W-1:khtu_pkg::VAL_W];
  assign rd_val   = rd_data_r[khtu_pkg::VAL_W-1:0];
  assign cmp_last = (cmp_pos_r == count_r - 1'b1);

  // Running minimum and maximum including the entry just read.
  always_comb begin
    if (cmp_pos_r == '0) begin
      mn_new = rd_val;
      mx_new = rd_val;
    end else begin
      mn_new = (rd_val < min_r) ? rd_val : min_r;
      mx_new = (rd_val > max_r) ? rd_val : max_r;
    end
  end

  // Controller: next state, memory access and result.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    oldest_nxt    = oldest_r;
    rd_pos_nxt    = rd_pos_r;
    cmp_vld_nxt   = 1'b0;
    cmp_slot_nxt  = cmp_slot_r;
    cmp_pos_nxt   = cmp_pos_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    res_found_nxt = res_found_r;
    res_key_nxt   = res_key_r;
    res_val_nxt   = res_val_r;
    res_min_nxt   = res_min_r;
    res_max_nxt   = res_max_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_found_nxt = out_found_r;
    out_key_nxt   = out_key_r;
    out_val_nxt   = out_val_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_cnt_nxt   = out_cnt_r;
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    wr_slot       = app_slot;
    wr_data       = {upd_key, upd_val};

    case (state_r)
      khtu_pkg::ST_IDLE: begin
        if (in_accept) begin
          op_nxt        = khtu_pkg::op_t'(in_chan.operation);
          key_nxt       = in_chan.day_key;
          val_nxt       = in_chan.new_value;
          rd_pos_nxt    = '0;
          res_found_nxt = 1'b0;
          res_key_nxt   = '0;
          res_val_nxt   = '0;
          res_min_nxt   = '0;
          res_max_nxt   = '0;
          state_nxt     = khtu_pkg::ST_DONE;
          case (khtu_pkg::op_t'(in_chan.operation))
            khtu_pkg::OP_UPSERT: begin
              if (count_r == '0) begin
                // Empty table: append directly.
                wr_en         = 1'b1;
                count_nxt     = count_r + 1'b1;
                res_found_nxt = 1'b1;
              end else begin
                state_nxt = khtu_pkg::ST_SCAN;
              end
            end
            khtu_pkg::OP_READ_IDX: begin
              if (32'(in_chan.entry_index) < 32'(count_r)) begin
                rd_en     = 1'b1;
                state_nxt = khtu_pkg::ST_READ;
              end
            end
            khtu_pkg::OP_READ_LAST: begin
              if (count_r != '0) begin
                rd_en     = 1'b1;
                state_nxt = khtu_pkg::ST_READ;
              end
            end
            khtu_pkg::OP_CLEAR: begin
              count_nxt     = '0;
              oldest_nxt    = '0;
              res_found_nxt = 1'b1;
            end
            khtu_pkg::OP_SCAN: begin
              res_found_nxt = 1'b1;
              if (count_r != '0) begin
                state_nxt = khtu_pkg::ST_SCAN;
              end
            end
            default: begin
              res_found_nxt = 1'b0;
            end
          endcase
        end
      end

      khtu_pkg::ST_SCAN: begin
        // Issue one read per cycle while positions remain.
        if (rd_pos_r < count_r) begin
          rd_en        = 1'b1;
          rd_pos_nxt   = rd_pos_r + 1'b1;
          cmp_vld_nxt  = 1'b1;
          cmp_slot_nxt = rd_slot;
          cmp_pos_nxt  = rd_pos_r;
        end
        // Check the entry read in the previous cycle.
        if (cmp_vld_r) begin
          if (op_r == khtu_pkg::OP_UPSERT) begin
            if (rd_key == key_r) begin
              wr_en         = 1'b1;
              wr_slot       = cmp_slot_r;
              res_found_nxt = 1'b1;
              cmp_vld_nxt   = 1'b0;
              state_nxt     = khtu_pkg::ST_DONE;
            end else if (cmp_last) begin
              // Key absent: append, dropping the oldest when full.
              wr_en         = 1'b1;
              res_found_nxt = 1'b1;
              cmp_vld_nxt   = 1'b0;
              state_nxt     = khtu_pkg::ST_DONE;
              if (table_full) begin
                oldest_nxt = oldest_inc;
              end else begin
                count_nxt = count_r + 1'b1;
              end
            end
          end else begin
            min_nxt = mn_new;
            max_nxt = mx_new;
            if (cmp_last) begin
              res_min_nxt = mn_new;
              res_max_nxt = mx_new;
              cmp_vld_nxt = 1'b0;
              state_nxt   = khtu_pkg::ST_DONE;
            end
          end
        end
      end

      khtu_pkg::ST_READ: begin
        res_found_nxt = 1'b1;
        res_key_nxt   = rd_key;
        res_val_nxt   = rd_val;
        state_nxt     = khtu_pkg::ST_DONE;
      end

      khtu_pkg::ST_DONE: begin
        // Move the result into the output register once it is free.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_key_nxt   = res_key_r;
          out_val_nxt   = res_val_r;
          out_min_nxt   = res_min_r;
          out_max_nxt   = res_max_r;
          out_cnt_nxt   = khtu_pkg::ECNT_W'(count_r);
          state_nxt     = khtu_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = khtu_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_slot];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= khtu_pkg::ST_IDLE;
      count_r     <= '0;
      oldest_r    <= '0;
      rd_pos_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      oldest_r    <= oldest_nxt;
      rd_pos_r    <= rd_pos_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    cmp_slot_r  <= cmp_slot_nxt;
    cmp_pos_r   <= cmp_pos_nxt;
    min_r       <= min_nxt;
    max_r       <= max_nxt;
    res_found_r <= res_found_nxt;
    res_key_r   <= res_key_nxt;
    res_val_r   <= res_val_nxt;
    res_min_r   <= res_min_nxt;
    res_max_r   <= res_max_nxt;
    out_found_r <= out_found_nxt;
    out_key_r   <= out_key_nxt;
    out_val_r   <= out_val_nxt;
    out_min_r   <= out_min_nxt;
    out_max_r   <= out_max_nxt;
    out_cnt_r   <= out_cnt_nxt;
  end

  // Response channel.
  assign out_chan.valid       = out_valid_r;
  assign out_chan.found       = out_found_r;
  assign out_chan.out_key     = out_key_r;
  assign out_chan.out_value   = out_val_r;
  assign out_chan.min_value   = out_min_r;
  assign out_chan.max_value   = out_max_r;
  assign out_chan.entry_count = out_cnt_r;

endmodule

@@ design/khtu_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// khtu_checker: port-level checks of the keyed history table
// Watches the response channel and checks handshake and result rules.
// ---------------------------------------------------------------------------
module khtu_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        found,
  input logic [khtu_pkg::KEY_W-1:0]  out_key,
  input logic [khtu_pkg::VAL_W-1:0]  out_value,
  input logic [khtu_pkg::VAL_W-1:0]  min_value,
  input logic [khtu_pkg::VAL_W-1:0]  max_value,
  input logic [khtu_pkg::ECNT_W-1:0] entry_count
);

  // A stalled response transaction stays offered.
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("response valid dropped while stalled");

  // A failed lookup returns no entry data.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !found |-> out_key == '0 && out_value == '0)
    else $error("entry data reported without a hit");

  // An empty table never reports nonzero scan bounds.
  a_empty_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && entry_count == '0 |-> min_value == '0 && max_value == '0)
    else $error("scan bounds reported for an empty table");

  // The count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(entry_count) <= khtu_pkg::TABLE_DEPTH)
    else $error("entry count above table depth");

endmodule

bind keyed_history_table_upsert khtu_checker u_khtu_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .found       (out_chan.found),
  .out_key     (out_chan.out_key),
  .out_value   (out_chan.out_value),
  .min_value   (out_chan.min_value),
  .max_value   (out_chan.max_value),
  .entry_count (out_chan.entry_count)
);
